/* design/mpa_pkg.sv */
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared types, constants and helpers of the max pooling with argmax block.
// ----------------------------------------------------------------------------
package mpa_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int WIN_W        = 4;
	localparam int DIM_W        = 7;
	localparam int INDEX_W      = 12;
	localparam int PHASE_W      = 3;
	localparam int MAX_WINDOW   = 8;
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam logic [WIN_W-1:0] RST_WINDOW_SIZE = 4'd2;
	localparam logic [WIN_W-1:0] RST_STRIDE      = 4'd2;
	localparam logic [DIM_W-1:0] RST_PLANE_ROWS  = 7'd64;
	localparam logic [DIM_W-1:0] RST_PLANE_COLS  = 7'd64;

	typedef enum logic [1:0] {
		CFG_WINDOW_SIZE,
		CFG_STRIDE,
		CFG_PLANE_ROWS,
		CFG_PLANE_COLS
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] pixel_value;
		logic                       end_of_batch;
	} pixel_req_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] max_value;
		logic [INDEX_W-1:0]         max_index;
		logic                       geometry_error;
		logic                       last_in_plane;
		logic                       last_in_batch;
	} pool_res_t;

	typedef struct packed {
		logic             start;
		logic [WIN_W-1:0] window_size;
		logic [DIM_W-1:0] plane_cols;
	} scan_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scan_sts_t;

	typedef struct packed {
		logic busy;
		logic bad;
	} geom_sts_t;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_READ,
		SCAN_LAST,
		SCAN_DONE
	} scan_state_t;

	// Phase of the next position: held at zero inside the lead-in of one
	// window, then counts modulo the stride.
	function automatic logic [PHASE_W-1:0] phase_next(
		input logic               in_lead,
		input logic [PHASE_W-1:0] phase,
		input logic [WIN_W-1:0]   stride
	);
		logic [WIN_W-1:0] inc;
		inc = {1'b0, phase} + 4'd1;
		if (in_lead || stride == '0) begin
			phase_next = '0;
		end else if (inc >= stride) begin
			phase_next = '0;
		end else begin
			phase_next = inc[PHASE_W-1:0];
		end
	endfunction

endpackage

/* design/max_pool_with_argmax_top.sv */
// ----------------------------------------------------------------------------
// max_pool_with_argmax_top
// Max pooling with argmax over raster-order planes held in a frame store.
//
// Channel  Dir  Handshake                Payload
// in       in   in_valid / in_stall      pixel_req_t
// out      out  out_valid / out_stall    pool_res_t
// cfg      in   cfg_write_en             cfg_index, cfg_data
//
// A pixel that completes no window, or any pixel under a bad geometry, starts
// no reread. A pixel that completes a window stalls the input through its scan:
// one store read per window element through the single read port, then the
// last compare and the handoff to the output register.
// Each configuration write stalls the input while the geometry check runs.
// The frame store has no reset and no clearing pass; control clears at once.
// The input stalls while the output register holds a request that is stalled.
// ----------------------------------------------------------------------------
module max_pool_with_argmax_top #(
	parameter int MAX_ROWS = mpa_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = mpa_pkg::DEF_MAX_COLS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  mpa_pkg::pixel_req_t       in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output mpa_pkg::pool_res_t        out_data,
	input  logic                      cfg_write_en,
	input  mpa_pkg::cfg_reg_t         cfg_index,
	input  logic [mpa_pkg::DIM_W-1:0] cfg_data
);
	import mpa_pkg::*;

	localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int IDX_W       = ROW_W + ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic [WIN_W-1:0] window_size_q;
	logic [WIN_W-1:0] stride_q;
	logic [DIM_W-1:0] plane_rows_q;
	logic [DIM_W-1:0] plane_cols_q;

	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [PHASE_W-1:0] row_phase_q;
	logic [PHASE_W-1:0] col_phase_q;
	logic               last_plane_q;
	logic               last_batch_q;

	logic      out_valid_q;
	pool_res_t out_data_q;

	geom_sts_t geom_sts;
	scan_ctl_t scan_ctl;
	scan_sts_t scan_sts;

	logic [IDX_W-1:0]           r_ext, c_ext, r_nxt, c_nxt;
	logic [IDX_W-1:0]           win_ext, rows_ext, cols_ext;
	logic [IDX_W-1:0]           wr_idx, base_idx;
	logic [IDX_W-1:0]           rd_idx;
	logic [IDX_W-1:0]           best_index;
	logic signed [SAMPLE_W-1:0] best_value;
	logic [SAMPLE_W-1:0]        rd_raw;
	logic signed [SAMPLE_W-1:0] rd_data;
	logic                       rd_en;
	logic                       accept;
	logic                       out_free;
	logic                       win_hit;
	logic                       err_load;
	logic                       scan_load;
	logic                       last_plane;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= RST_WINDOW_SIZE;
			stride_q      <= RST_STRIDE;
			plane_rows_q  <= RST_PLANE_ROWS;
			plane_cols_q  <= RST_PLANE_COLS;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_WINDOW_SIZE: window_size_q <= cfg_data[WIN_W-1:0];
				CFG_STRIDE:      stride_q      <= cfg_data[WIN_W-1:0];
				CFG_PLANE_ROWS:  plane_rows_q  <= cfg_data;
				CFG_PLANE_COLS:  plane_cols_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	mpa_geom #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_geom (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (cfg_write_en),
		.window_size (window_size_q),
		.stride      (stride_q),
		.plane_rows  (plane_rows_q),
		.plane_cols  (plane_cols_q),
		.sts         (geom_sts)
	);

	// Position arithmetic for the incoming pixel
	always_comb begin
		r_ext    = IDX_W'(row_q);
		c_ext    = IDX_W'(col_q);
		r_nxt    = r_ext + IDX_W'(1);
		c_nxt    = c_ext + IDX_W'(1);
		win_ext  = IDX_W'(window_size_q);
		rows_ext = IDX_W'(plane_rows_q);
		cols_ext = IDX_W'(plane_cols_q);
		wr_idx   = IDX_W'(r_ext * cols_ext) + c_ext;
		base_idx = IDX_W'((r_nxt - win_ext) * cols_ext) + (c_nxt - win_ext);
		win_hit  = !geom_sts.bad && (r_ext < rows_ext) && (c_ext < cols_ext) &&
			(r_nxt >= win_ext) && (c_nxt >= win_ext) &&
			(row_phase_q == '0) && (col_phase_q == '0);
		last_plane = (r_nxt == rows_ext) && (c_nxt == cols_ext);
	end

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = geom_sts.busy || scan_sts.busy || !out_free;
	assign accept    = in_valid && !in_stall;
	assign err_load  = accept && geom_sts.bad;
	assign scan_load = scan_sts.done && out_free;

	// Raster counters and window phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			row_phase_q <= '0;
			col_phase_q <= '0;
		end else if (accept) begin
			if (in_data.end_of_batch) begin
				row_q       <= '0;
				col_q       <= '0;
				row_phase_q <= '0;
				col_phase_q <= '0;
			end else if (c_nxt >= cols_ext) begin
				col_q       <= '0;
				col_phase_q <= '0;
				if (r_nxt >= rows_ext) begin
					row_q       <= '0;
					row_phase_q <= '0;
				end else begin
					row_phase_q <= phase_next(r_nxt + IDX_W'(1) <= win_ext, row_phase_q,
						stride_q);
					row_q       <= r_nxt[ROW_W-1:0];
				end
			end else begin
				col_phase_q <= phase_next(c_nxt + IDX_W'(1) <= win_ext, col_phase_q, stride_q);
				col_q       <= c_nxt[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && win_hit) begin
			last_plane_q <= last_plane;
			last_batch_q <= last_plane && in_data.end_of_batch;
		end
	end

	mpa_store #(
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (SAMPLE_W)
	) u_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (wr_idx[ADDR_W-1:0]),
		.wr_data (in_data.pixel_value),
		.rd_en   (rd_en),
		.rd_addr (rd_idx[ADDR_W-1:0]),
		.rd_data (rd_raw)
	);

	assign rd_data = $signed(rd_raw);

	assign scan_ctl.start       = accept && win_hit;
	assign scan_ctl.window_size = window_size_q;
	assign scan_ctl.plane_cols  = plane_cols_q;

	mpa_scan #(
		.IDX_W(IDX_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.base       (base_idx),
		.done_ack   (scan_load),
		.rd_data    (rd_data),
		.rd_en      (rd_en),
		.rd_idx     (rd_idx),
		.sts        (scan_sts),
		.best_value (best_value),
		.best_index (best_index)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (err_load || scan_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (err_load) begin
			out_data_q.max_value      <= '0;
			out_data_q.max_index      <= '0;
			out_data_q.geometry_error <= 1'b1;
			out_data_q.last_in_plane  <= 1'b0;
			out_data_q.last_in_batch  <= 1'b0;
		end else if (scan_load) begin
			out_data_q.max_value      <= best_value;
			out_data_q.max_index      <= INDEX_W'(best_index);
			out_data_q.geometry_error <= 1'b0;
			out_data_q.last_in_plane  <= last_plane_q;
			out_data_q.last_in_batch  <= last_batch_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Handing a finished window to the output retires the scan at once.
	a_scan_retire: assert property (@(posedge clk) disable iff (!arst_n)
		scan_sts.done && out_free |=> !scan_sts.done)
		else $error("scan result handed over twice");

	a_cfg_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write_en |=> in_stall)
		else $error("pixel taken during geometry check");

	a_err_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.geometry_error |->
			out_data.max_index == '0 && !out_data.last_in_plane && !out_data.last_in_batch)
		else $error("error request carries pooled fields");

	a_batch_in_plane: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_data.last_in_batch || out_data.last_in_plane)
		else $error("batch end without plane end");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !accept)
		else $error("store written during window reread");

endmodule

/* design/mpa_store.sv */
// ----------------------------------------------------------------------------
// mpa_store
// Frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mpa_store #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* design/mpa_geom.sv */
// ----------------------------------------------------------------------------
// mpa_geom
// Geometry check: range tests plus a bit-serial remainder of the spare rows
// and columns by the stride, rerun after every configuration write.
// ----------------------------------------------------------------------------
module mpa_geom #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [mpa_pkg::WIN_W-1:0] window_size,
	input  logic [mpa_pkg::WIN_W-1:0] stride,
	input  logic [mpa_pkg::DIM_W-1:0] plane_rows,
	input  logic [mpa_pkg::DIM_W-1:0] plane_cols,
	output mpa_pkg::geom_sts_t       sts
);
	import mpa_pkg::*;

	localparam int LIM_W = 11;
	localparam logic [LIM_W-1:0] ROWS_LIM = LIM_W'(MAX_ROWS);
	localparam logic [LIM_W-1:0] COLS_LIM = LIM_W'(MAX_COLS);
	localparam logic [WIN_W-1:0] WIN_LIM  = WIN_W'(MAX_WINDOW);
	localparam logic [2:0]       STEP_LOAD  = 3'd7;
	localparam logic [2:0]       STEP_FIRST = 3'd6;
	localparam logic [2:0]       STEP_LAST  = 3'd0;

	logic             busy_q;
	logic             bad_q;
	logic [2:0]       step_q;
	logic [DIM_W-1:0] rem_r_q;
	logic [DIM_W-1:0] rem_c_q;
	logic [DIM_W-1:0] rem_r_nxt;
	logic [DIM_W-1:0] rem_c_nxt;
	logic [LIM_W-1:0] sub_val;
	logic             range_bad;

	always_comb begin
		range_bad = (window_size == '0) || (window_size > WIN_LIM) ||
			(stride == '0) || (stride > WIN_LIM) ||
			(plane_rows == '0) || ({4'b0, plane_rows} > ROWS_LIM) ||
			(plane_cols == '0) || ({4'b0, plane_cols} > COLS_LIM) ||
			({3'b0, window_size} > plane_rows) ||
			({3'b0, window_size} > plane_cols);
	end

	// Restoring remainder, one shifted stride a cycle.
	always_comb begin
		sub_val   = {7'b0, stride} << step_q;
		rem_r_nxt = ({4'b0, rem_r_q} >= sub_val) ? rem_r_q - sub_val[DIM_W-1:0] : rem_r_q;
		rem_c_nxt = ({4'b0, rem_c_q} >= sub_val) ? rem_c_q - sub_val[DIM_W-1:0] : rem_c_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bad_q  <= 1'b0;
			step_q <= STEP_LOAD;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_LOAD;
		end else if (busy_q) begin
			if (step_q == STEP_LOAD) begin
				step_q <= STEP_FIRST;
			end else if (step_q == STEP_LAST) begin
				busy_q <= 1'b0;
				bad_q  <= range_bad || (rem_r_nxt != '0) || (rem_c_nxt != '0);
			end else begin
				step_q <= step_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && step_q == STEP_LOAD) begin
			rem_r_q <= plane_rows - {3'b0, window_size};
			rem_c_q <= plane_cols - {3'b0, window_size};
		end else if (busy_q) begin
			rem_r_q <= rem_r_nxt;
			rem_c_q <= rem_c_nxt;
		end
	end

	assign sts.busy = busy_q;
	assign sts.bad  = bad_q;

endmodule

/* design/mpa_scan.sv */
// ----------------------------------------------------------------------------
// mpa_scan
// Window scanner: rereads one window from the frame store in row-major order
// and keeps the running maximum and its position.
// ----------------------------------------------------------------------------
module mpa_scan #(
	parameter int IDX_W = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mpa_pkg::scan_ctl_t                  ctl,
	input  logic [IDX_W-1:0]                    base,
	input  logic                                done_ack,
	input  logic signed [mpa_pkg::SAMPLE_W-1:0] rd_data,
	output logic                                rd_en,
	output logic [IDX_W-1:0]                    rd_idx,
	output mpa_pkg::scan_sts_t                  sts,
	output logic signed [mpa_pkg::SAMPLE_W-1:0] best_value,
	output logic [IDX_W-1:0]                    best_index
);
	import mpa_pkg::*;

	scan_state_t state_q;
	scan_state_t state_nxt;

	logic [2:0]                 win_last_q;
	logic [DIM_W-1:0]           cols_q;
	logic [IDX_W-1:0]           addr_q;
	logic [IDX_W-1:0]           row_base_q;
	logic [2:0]                 wc_q;
	logic [2:0]                 hc_q;
	logic                       first_q;
	logic                       vld_s1;
	logic                       first_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic signed [SAMPLE_W-1:0] best_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic                       row_end;
	logic                       last_elem;

	assign row_end   = (wc_q == win_last_q);
	assign last_elem = row_end && (hc_q == win_last_q);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			SCAN_IDLE: if (ctl.start) state_nxt = SCAN_READ;
			SCAN_READ: if (last_elem) state_nxt = SCAN_LAST;
			SCAN_LAST: state_nxt = SCAN_DONE;
			SCAN_DONE: if (done_ack) state_nxt = SCAN_IDLE;
			default:   state_nxt = SCAN_IDLE;
		endcase
	end

	always_comb begin
		rd_en    = 1'b0;
		sts.busy = 1'b1;
		sts.done = 1'b0;
		case (state_q)
			SCAN_IDLE: sts.busy = 1'b0;
			SCAN_READ: rd_en = 1'b1;
			SCAN_LAST: rd_en = 1'b0;
			SCAN_DONE: sts.done = 1'b1;
			default:   sts.busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			vld_s1  <= rd_en;
		end
	end

	// Address walk: step along a row, jump one plane row at its end.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			addr_q     <= base;
			row_base_q <= base;
			wc_q       <= '0;
			hc_q       <= '0;
			first_q    <= 1'b1;
			win_last_q <= 3'(ctl.window_size - 4'd1);
			cols_q     <= ctl.plane_cols;
		end else if (rd_en) begin
			first_q <= 1'b0;
			if (row_end) begin
				wc_q       <= '0;
				hc_q       <= hc_q + 3'd1;
				row_base_q <= row_base_q + IDX_W'(cols_q);
				addr_q     <= row_base_q + IDX_W'(cols_q);
			end else begin
				wc_q   <= wc_q + 3'd1;
				addr_q <= addr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= addr_q;
		first_s1 <= first_q;
		// Strictly larger only, so a tie keeps the earlier position.
		if (vld_s1 && (first_s1 || rd_data > best_q)) begin
			best_q     <= rd_data;
			best_idx_q <= idx_s1;
		end
	end

	assign rd_idx     = addr_q;
	assign best_value = best_q;
	assign best_index = best_idx_q;

endmodule
